>>> sv/lzt_pkg.sv
// lzt_pkg: constants, codes and state type shared by the lz77 triple encoder
package lzt_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WINDOW_SIZE    = 1024;
    localparam int unsigned LOOKAHEAD_SIZE = 100;
    // power of two, positions wrap by truncation
    localparam int unsigned RING_DEPTH     = 2048;
    localparam int unsigned RING_AW        = $clog2(RING_DEPTH);

    localparam int unsigned OFF_W  = 11;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned HIST_W = $clog2(WINDOW_SIZE + 1);
    localparam int unsigned PEND_W = $clog2(LOOKAHEAD_SIZE + 2);
    localparam int unsigned CNT_W  = $clog2(LOOKAHEAD_SIZE + 1);

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SYM_RD,
        S_EMIT
    } t_state;

endpackage

>>> sv/lzt_if.sv
// lzt_if: valid/ready channels for input requests and output triples
interface lzt_in_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [lzt_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface lzt_out_if;
    logic                       valid;
    logic                       ready;
    logic [lzt_pkg::OFF_W-1:0]  match_offset;
    logic [lzt_pkg::LEN_W-1:0]  match_length;
    logic [lzt_pkg::BYTE_W-1:0] next_symbol;
    logic                       final_tuple;

    modport source (output valid, output match_offset, output match_length,
                    output next_symbol, output final_tuple, input ready);
    modport sink   (input valid, input match_offset, input match_length,
                    input next_symbol, input final_tuple, output ready);
endinterface

>>> sv/lz77_triple_encoder.sv
// lz77_triple_encoder: byte ring with brute-force window search, one triple out
//
//   channel  dir  payload                                              item
//   i_in     in   req_type, data_byte                                  byte or drain step
//   o_out    out  match_offset, match_length, next_symbol, final_tuple triple
//
// a byte that codes nothing is taken while idle and the encoder stays idle; a triple takes,
// for each byte compared over every tried offset, a ring read at two addresses and then a compare,
// plus the accept, the symbol read and the emit, which waits while the output holds an untaken triple
// one item is worked at a time; i_in.ready is high only while idle
// the output register holds a triple until taken, the next search runs meanwhile
// reset clears pointers and counts; ring contents are left as they are
module lz77_triple_encoder (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lzt_in_if.sink    i_in,
    lzt_out_if.source o_out
);
    import lzt_pkg::*;

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [BYTE_W-1:0] r_rd_a, r_rd_b;

    t_state             r_state, n_state;
    logic [RING_AW-1:0] r_wp, n_wp;
    logic [RING_AW-1:0] r_cp, n_cp;
    logic [HIST_W-1:0]  r_hist, n_hist;
    logic [PEND_W-1:0]  r_pend, n_pend;
    logic               r_drain, n_drain;
    logic [HIST_W-1:0]  r_maxd, n_maxd;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic [HIST_W-1:0]  r_d, n_d;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [HIST_W-1:0]  r_off, n_off;

    logic               r_out_valid, n_out_valid;
    logic [OFF_W-1:0]   r_out_off, n_out_off;
    logic [LEN_W-1:0]   r_out_len, n_out_len;
    logic [BYTE_W-1:0]  r_out_sym, n_out_sym;
    logic               r_out_fin, n_out_fin;

    logic               accept, start, out_free;
    logic [PEND_W-1:0]  pend_inc, start_pend;
    logic [CNT_W-1:0]   cnt1, run_len, sym_idx, consume;
    logic               eq, run_more, cmp_done, last_d;
    logic               ring_we, rd_en, fin;
    logic [RING_AW-1:0] addr_a, addr_b;
    logic [HIST_W:0]    hist_sum;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign pend_inc = r_pend + PEND_W'(1);

    // start of a search and its loop controls
    always_comb begin
        start_pend = r_pend;
        start      = 1'b0;
        if (i_in.req_type == REQ_DATA) begin
            start_pend = pend_inc;
            start      = pend_inc >= PEND_W'(LOOKAHEAD_SIZE + 1);
        end else begin
            start      = r_pend != '0;
        end
        eq       = r_rd_a == r_rd_b;
        cnt1     = r_cnt + CNT_W'(1);
        run_more = (cnt1 < r_limit) && (HIST_W'(cnt1) < r_d);
        cmp_done = !eq || !run_more;
        run_len  = eq ? cnt1 : r_cnt;
        last_d   = r_d == r_maxd;
        if (r_best == '0) begin
            sym_idx = '0;
            consume = CNT_W'(1);
        end else if (PEND_W'(r_best) < r_pend) begin
            sym_idx = r_best;
            consume = r_best + CNT_W'(1);
        end else begin
            sym_idx = r_best - CNT_W'(1);
            consume = r_best;
        end
        fin      = r_drain && (PEND_W'(consume) == r_pend);
        hist_sum = {1'b0, r_hist} + (HIST_W + 1)'(consume);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && start) begin
                    n_state = (r_hist == '0) ? S_SYM_RD : S_READ;
                end
            end
            S_READ:   n_state = S_CMP;
            S_CMP: begin
                if (!cmp_done) begin
                    n_state = S_READ;
                end else if (last_d) begin
                    n_state = S_SYM_RD;
                end else begin
                    n_state = S_READ;
                end
            end
            S_SYM_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_wp        = r_wp;
        n_cp        = r_cp;
        n_hist      = r_hist;
        n_pend      = r_pend;
        n_drain     = r_drain;
        n_maxd      = r_maxd;
        n_limit     = r_limit;
        n_d         = r_d;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_off       = r_off;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_off   = r_out_off;
        n_out_len   = r_out_len;
        n_out_sym   = r_out_sym;
        n_out_fin   = r_out_fin;
        ring_we     = 1'b0;
        rd_en       = 1'b0;
        addr_a      = r_cp + RING_AW'(r_cnt) - RING_AW'(r_d);
        addr_b      = r_cp + RING_AW'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.req_type == REQ_DATA) begin
                        ring_we = 1'b1;
                        n_wp    = r_wp + RING_AW'(1);
                        n_pend  = pend_inc;
                    end
                    n_drain = i_in.req_type == REQ_DRAIN;
                    n_limit = (start_pend < PEND_W'(LOOKAHEAD_SIZE)) ?
                              CNT_W'(start_pend) : CNT_W'(LOOKAHEAD_SIZE);
                    n_maxd  = (r_hist < HIST_W'(WINDOW_SIZE)) ?
                              r_hist : HIST_W'(WINDOW_SIZE);
                    n_d     = HIST_W'(1);
                    n_cnt   = '0;
                    n_best  = '0;
                    n_off   = '0;
                end
            end
            S_READ: begin
                rd_en = 1'b1;
            end
            S_CMP: begin
                if (!cmp_done) begin
                    n_cnt = cnt1;
                end else begin
                    if (run_len > r_best) begin
                        n_best = run_len;
                        n_off  = r_d;
                    end
                    n_cnt = '0;
                    n_d   = r_d + HIST_W'(1);
                end
            end
            S_SYM_RD: begin
                rd_en  = 1'b1;
                addr_b = r_cp + RING_AW'(sym_idx);
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_off   = OFF_W'(r_off);
                    n_out_len   = LEN_W'(r_best);
                    n_out_sym   = r_rd_b;
                    n_out_fin   = fin;
                    n_cp        = r_cp + RING_AW'(consume);
                    n_pend      = r_pend - PEND_W'(consume);
                    if (fin) begin
                        n_hist = '0;
                    end else if (hist_sum > (HIST_W + 1)'(WINDOW_SIZE)) begin
                        n_hist = HIST_W'(WINDOW_SIZE);
                    end else begin
                        n_hist = HIST_W'(hist_sum);
                    end
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign i_in.ready         = r_state == S_IDLE;
    assign o_out.valid        = r_out_valid;
    assign o_out.match_offset = r_out_off;
    assign o_out.match_length = r_out_len;
    assign o_out.next_symbol  = r_out_sym;
    assign o_out.final_tuple  = r_out_fin;

    // byte ring, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wp] <= i_in.data_byte;
        end
        if (rd_en) begin
            r_rd_a <= r_ring[addr_a];
            r_rd_b <= r_ring[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_cp        <= '0;
            r_hist      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_cp        <= n_cp;
            r_hist      <= n_hist;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_drain   <= n_drain;
        r_maxd    <= n_maxd;
        r_limit   <= n_limit;
        r_d       <= n_d;
        r_cnt     <= n_cnt;
        r_best    <= n_best;
        r_off     <= n_off;
        r_out_off <= n_out_off;
        r_out_len <= n_out_len;
        r_out_sym <= n_out_sym;
        r_out_fin <= n_out_fin;
    end

endmodule

>>> sv/lzt_checker.sv
// lzt_checker: port-level assertions on the lz77 triple encoder, bound to the top level
module lzt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [lzt_pkg::OFF_W-1:0]  i_match_offset,
    input logic [lzt_pkg::LEN_W-1:0]  i_match_length,
    input logic [lzt_pkg::BYTE_W-1:0] i_next_symbol,
    input logic                       i_final_tuple
);
    import lzt_pkg::*;

    // no triple straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output item valid after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_match_offset) && $stable(i_match_length)
            && $stable(i_next_symbol) && $stable(i_final_tuple))
        else $error("stalled output item changed");

    // no match means no offset, and a match has one
    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_match_length == '0) == (i_match_offset == '0)))
        else $error("offset and length disagree on a match");

    // match stays behind the coding position and within limits
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (OFF_W'(i_match_length) <= i_match_offset)
            && (i_match_offset <= OFF_W'(WINDOW_SIZE))
            && (i_match_length <= LEN_W'(LOOKAHEAD_SIZE)))
        else $error("match out of bounds");

endmodule

bind lz77_triple_encoder lzt_checker u_lzt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_match_offset (o_out.match_offset),
    .i_match_length (o_out.match_length),
    .i_next_symbol  (o_out.next_symbol),
    .i_final_tuple  (o_out.final_tuple)
);

>>> dv/tb_top.sv
// tb_top: self-checking bench for the lz77 triple encoder with its own triple predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lzt_pkg::*;

    localparam int unsigned DIRECTED_ROWS  = 24;
    localparam int unsigned ROW_AW         = $clog2(DIRECTED_ROWS);
    localparam int unsigned MOTIF_AW       = 3;
    localparam int unsigned RANDOM_ITEMS   = 556;
    localparam int unsigned WATCHDOG_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] sym;
        logic              fin;
    } t_triple;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_TRIPLE
    } t_row_kind;

    typedef struct packed {
        logic              req;
        logic [BYTE_W-1:0] data;
        t_row_kind         kind;
        t_triple           exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lzt_in_if  u_in ();
    lzt_out_if u_out ();

    lz77_triple_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    // predictor state
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       code_ptr;
    int unsigned       hist_fill;
    int unsigned       pend_cnt;

    t_triple     triples_due [$];
    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          steady;

    t_row stim_rows [DIRECTED_ROWS] = '{
        '{REQ_DRAIN, 8'hFF, ROW_NONE,   '0},
        '{REQ_DATA,  8'h00, ROW_NONE,   '0},
        '{REQ_DRAIN, 8'h00, ROW_TRIPLE, '{11'd0, 7'd0, 8'h00, 1'b1}},
        '{REQ_DATA,  8'hFF, ROW_NONE,   '0},
        '{REQ_DRAIN, 8'h00, ROW_TRIPLE, '{11'd0, 7'd0, 8'hFF, 1'b1}},
        '{REQ_DRAIN, 8'h5A, ROW_NONE,   '0},
        '{REQ_DATA,  8'h41, ROW_NONE,   '0},
        '{REQ_DATA,  8'h42, ROW_NONE,   '0},
        '{REQ_DATA,  8'h41, ROW_NONE,   '0},
        '{REQ_DATA,  8'h42, ROW_NONE,   '0},
        '{REQ_DRAIN, 8'hFF, ROW_TRIPLE, '{11'd0, 7'd0, 8'h41, 1'b0}},
        '{REQ_DRAIN, 8'h00, ROW_TRIPLE, '{11'd0, 7'd0, 8'h42, 1'b0}},
        '{REQ_DRAIN, 8'hA5, ROW_TRIPLE, '{11'd2, 7'd2, 8'h42, 1'b1}},
        '{REQ_DATA,  8'h5A, ROW_NONE,   '0},
        '{REQ_DATA,  8'h5A, ROW_NONE,   '0},
        '{REQ_DRAIN, 8'h00, ROW_TRIPLE, '{11'd0, 7'd0, 8'h5A, 1'b0}},
        '{REQ_DATA,  8'h5A, ROW_NONE,   '0},
        '{REQ_DRAIN, 8'h00, ROW_TRIPLE, '{11'd1, 7'd1, 8'h5A, 1'b1}},
        '{REQ_DATA,  8'h80, ROW_PREDICT, '0},
        '{REQ_DATA,  8'h01, ROW_PREDICT, '0},
        '{REQ_DATA,  8'h80, ROW_PREDICT, '0},
        '{REQ_DATA,  8'h01, ROW_PREDICT, '0},
        '{REQ_DRAIN, 8'h3C, ROW_PREDICT, '0},
        '{REQ_DRAIN, 8'hC3, ROW_PREDICT, '0}
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [BYTE_W-1:0] ring_byte(int unsigned ahead, int unsigned back);
        return ring_mem[RING_AW'(code_ptr + ahead + RING_DEPTH - back)];
    endfunction

    // one triple over the pending bytes, window search nearest first
    function automatic t_triple code_triple(bit draining);
        int unsigned       lim;
        int unsigned       maxd;
        int unsigned       best;
        int unsigned       off;
        int unsigned       cnt;
        int unsigned       d;
        int unsigned       consume;
        logic [BYTE_W-1:0] sym;
        bit                fin;
        t_triple           t;
        lim  = (pend_cnt < LOOKAHEAD_SIZE) ? pend_cnt : LOOKAHEAD_SIZE;
        maxd = (hist_fill < WINDOW_SIZE) ? hist_fill : WINDOW_SIZE;
        best = 0;
        off  = 0;
        for (d = 1; d <= maxd; d++) begin
            cnt = 0;
            while (cnt < lim && cnt < d && ring_byte(cnt, d) == ring_byte(cnt, 0))
                cnt++;
            if (cnt > best) begin
                best = cnt;
                off  = d;
            end
        end
        if (best == 0) begin
            sym     = ring_byte(0, 0);
            consume = 1;
        end else if (best < pend_cnt) begin
            sym     = ring_byte(best, 0);
            consume = best + 1;
        end else begin
            // match runs to the end of the stream
            sym     = ring_byte(best - 1, 0);
            consume = best;
        end
        if (consume > pend_cnt)
            consume = pend_cnt;
        fin = draining && (consume == pend_cnt);

        t.off = OFF_W'(off);
        t.len = LEN_W'(best);
        t.sym = sym;
        t.fin = fin;

        code_ptr  = (code_ptr + consume) % RING_DEPTH;
        pend_cnt  = pend_cnt - consume;
        hist_fill = hist_fill + consume;
        if (hist_fill > WINDOW_SIZE)
            hist_fill = WINDOW_SIZE;
        if (fin)
            hist_fill = 0;
        return t;
    endfunction

    function automatic bit step_encoder(logic req, logic [BYTE_W-1:0] b, output t_triple t);
        t = '0;
        if (req == REQ_DATA) begin
            ring_mem[RING_AW'(wr_ptr)] = b;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            pend_cnt++;
            if (pend_cnt >= LOOKAHEAD_SIZE + 1) begin
                t = code_triple(1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (pend_cnt == 0)
            return 1'b0;
        t = code_triple(1'b1);
        return 1'b1;
    endfunction

    task automatic send_item(logic req, logic [BYTE_W-1:0] b, t_row_kind kind, t_triple typed);
        int unsigned gap;
        t_triple     t;
        bit          has;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_in.valid     <= 1'b1;
        u_in.req_type  <= req;
        u_in.data_byte <= b;
        @(posedge i_clk);
        while (!u_in.ready) @(posedge i_clk);
        has = step_encoder(req, b, t);
        case (kind)
            ROW_PREDICT: begin
                if (has)
                    triples_due.push_back(t);
            end
            ROW_TRIPLE: begin
                triples_due.push_back(typed);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_triple(t_triple got);
        t_triple want;
        if (triples_due.size() == 0) begin
            $display("%0t: expected no triple, actual off=%0d len=%0d sym=%02h fin=%0b",
                     $time, got.off, got.len, got.sym, got.fin);
            errors++;
            return;
        end
        want = triples_due.pop_front();
        if (got.off !== want.off) begin
            $display("%0t: match_offset expected %0d actual %0d", $time, want.off, got.off);
            errors++;
        end
        if (got.len !== want.len) begin
            $display("%0t: match_length expected %0d actual %0d", $time, want.len, got.len);
            errors++;
        end
        if (got.sym !== want.sym) begin
            $display("%0t: next_symbol expected %02h actual %02h", $time, want.sym, got.sym);
            errors++;
        end
        if (got.fin !== want.fin) begin
            $display("%0t: final_tuple expected %0b actual %0b", $time, want.fin, got.fin);
            errors++;
        end
    endtask

    // output side: take triples with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_out.ready <= 1'b0;
            stall_left = 0;
        end else if (u_out.valid && u_out.ready) begin
            check_triple(t_triple'{u_out.match_offset, u_out.match_length,
                                   u_out.next_symbol, u_out.final_tuple});
            stall_left = steady ? 0 : $urandom_range(0, 3);
            if (stall_left != 0) begin
                u_out.ready <= 1'b0;
                stall_left--;
            end
        end else if (!u_out.ready) begin
            if (stall_left == 0)
                u_out.ready <= 1'b1;
            else
                stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned       done_items;
        int unsigned       style;
        int unsigned       len;
        int unsigned       period;
        int unsigned       drains;
        int unsigned       i;
        logic [BYTE_W-1:0] motif [8];
        logic [BYTE_W-1:0] b;

        i_rst_n        = 1'b0;
        u_in.valid     = 1'b0;
        u_in.req_type  = REQ_DATA;
        u_in.data_byte = '0;
        u_out.ready    = 1'b0;
        wr_ptr         = 0;
        code_ptr       = 0;
        hist_fill      = 0;
        pend_cnt       = 0;
        errors         = 0;
        idle_cycles    = 0;
        steady         = 1'b0;
        done_items     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_item(stim_rows[ROW_AW'(i)].req, stim_rows[ROW_AW'(i)].data,
                      stim_rows[ROW_AW'(i)].kind, stim_rows[ROW_AW'(i)].exp);

        // random streams: data bytes with random or patterned content, then drain steps
        while (done_items < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            style  = $urandom_range(0, 3);
            len    = ($urandom_range(0, 2) == 0) ? $urandom_range(101, 240)
                                                 : $urandom_range(1, 40);
            if (len > RANDOM_ITEMS - done_items)
                len = RANDOM_ITEMS - done_items;
            period = (style == 3) ? 1 : $urandom_range(1, 8);
            for (i = 0; i < 8; i++)
                motif[MOTIF_AW'(i)] = BYTE_W'($urandom_range(0, 255));
            for (i = 0; i < len; i++) begin
                case (style)
                    0: b = BYTE_W'($urandom_range(0, 255));
                    1: b = motif[MOTIF_AW'($urandom_range(0, 1))];
                    default: b = ($urandom_range(0, 15) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                              : motif[MOTIF_AW'(i % period)];
                endcase
                send_item(REQ_DATA, b, ROW_PREDICT, '0);
                done_items++;
            end
            if ($urandom_range(0, 4) == 0 && pend_cnt > 1) begin
                // drain steps fewer than the pending bytes, the next stream appends
                drains = $urandom_range(1, pend_cnt - 1);
                repeat (drains) begin
                    if (pend_cnt != 0)
                        done_items++;
                    send_item(REQ_DRAIN, BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
                end
            end else begin
                while (pend_cnt != 0) begin
                    send_item(REQ_DRAIN, BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
                    done_items++;
                end
                if ($urandom_range(0, 2) == 0)
                    send_item(REQ_DRAIN, BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
            end
        end
        u_in.valid <= 1'b0;
        steady = 1'b0;

        while (triples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && triples_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
